// ===== hw/rtl/lsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Logistic sigmoid unit package
// Shared stage buses, widths and the constant table of e^-(2^k/1024).
// ----------------------------------------------------------------------------
package lsu_pkg;

    localparam int ExpSteps = 16;
    localparam int QuotBits = 17;

    // Bus through the exponential stages.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        neg;
        logic [15:0] mag;
        logic        one;   // E is still exactly 1.0
        logic [31:0] e;
    } t_exp_bus;

    // Bus through the division stages.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        neg;
        logic [32:0] d;
        logic [32:0] rem;
        logic [16:0] nlo;
        logic [16:0] quot;
    } t_div_bus;

    // Q0.32 value of e^-(2^k/1024), built exactly as the squaring chain defines it.
    function automatic logic [31:0] exp_tab(input int k);
        logic [63:0] v;
        logic [63:0] t;
        v = (64'd1 << 60) - (64'd1 << 50) + (64'd1 << 39)
            - ((64'd1 << 30) / 64'd6) + ((64'd1 << 20) / 64'd24)
            - ((64'd1 << 10) / 64'd120);
        t = (v + (64'd1 << 27)) >> 28;
        for (int i = 1; i < ExpSteps; i++) begin
            if (i <= k) begin
                t = (t * t + (64'd1 << 31)) >> 32;
            end
        end
        return t[31:0];
    endfunction

endpackage

// ===== hw/rtl/lsu_exp_stage.sv =====
// ----------------------------------------------------------------------------
// Exponential stage
// Multiplies the running value E by e^-(2^K/1024) when bit K of |x| is set.
// ----------------------------------------------------------------------------
module lsu_exp_stage #(
    parameter int K = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  lsu_pkg::t_exp_bus i_bus,
    output lsu_pkg::t_exp_bus o_bus
);

    localparam logic [31:0] Tk = lsu_pkg::exp_tab(K);

    lsu_pkg::t_exp_bus r_bus;
    lsu_pkg::t_exp_bus n_bus;
    logic [63:0]       prod;

    // Rounded Q0.32 product; E of exactly 1.0 just takes the table value.
    always_comb begin
        prod  = {32'd0, i_bus.e} * {32'd0, Tk} + (64'd1 << 31);
        n_bus = i_bus;
        if (i_bus.mag[K]) begin
            n_bus.one = 1'b0;
            n_bus.e   = i_bus.one ? Tk : prod[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== hw/rtl/lsu_div_stage.sv =====
// ----------------------------------------------------------------------------
// Division stage
// One restoring step of the rounded quotient, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lsu_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  lsu_pkg::t_div_bus i_bus,
    output lsu_pkg::t_div_bus o_bus
);

    lsu_pkg::t_div_bus r_bus;
    lsu_pkg::t_div_bus n_bus;
    logic [33:0]       trial;
    logic [33:0]       diff;

    // Bring down the next numerator bit and subtract the divisor if it fits.
    always_comb begin
        trial = {i_bus.rem, i_bus.nlo[16]};
        diff  = trial - {1'b0, i_bus.d};
        n_bus = i_bus;
        n_bus.nlo = {i_bus.nlo[15:0], 1'b0};
        if (trial >= {1'b0, i_bus.d}) begin
            n_bus.rem  = diff[32:0];
            n_bus.quot = {i_bus.quot[15:0], 1'b1};
        end else begin
            n_bus.rem  = trial[32:0];
            n_bus.quot = {i_bus.quot[15:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== hw/rtl/logistic_sigmoid_unit_core.sv =====
// ----------------------------------------------------------------------------
// Logistic sigmoid unit
// Streams matrix elements through y = 1/(1+e^-x), Q6.10 in, Q0.16 out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one element per item on i_x_in (signed Q6.10)
// with i_last_in marking the final element; the block drives o_stall.
// The output channel returns o_y_out (unsigned Q0.16, saturated at 65535)
// with o_last_out copied from the input; the receiver drives i_stall.
// Throughput is one item per clock cycle unless the receiver stalls. Each
// element on its way to o_valid passes through 36 register stages:
// one input register, sixteen exponential stages (one table multiply each),
// one stage that forms divisor and numerator, seventeen division stages
// (one quotient bit each) and the output register.
// The whole pipeline moves as one: while a result waits on a stalled
// receiver, every stage holds and o_stall is raised, so nothing is lost
// or repeated. Bubbles flow along with their cleared valid bits.
// Reset clears all valid bits; payload registers are left as they are.
// ----------------------------------------------------------------------------
module logistic_sigmoid_unit_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_x_in,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_y_out,
    output logic        o_last_out
);

    logic              en;
    lsu_pkg::t_exp_bus r_in;
    lsu_pkg::t_exp_bus n_in;
    lsu_pkg::t_exp_bus exp_bus [lsu_pkg::ExpSteps+1];
    lsu_pkg::t_div_bus r_prep;
    lsu_pkg::t_div_bus n_prep;
    lsu_pkg::t_div_bus div_bus [lsu_pkg::QuotBits+1];
    logic [32:0]       e33;
    logic [32:0]       dsum;
    logic [49:0]       num;
    logic              r_out_valid;
    logic [15:0]       r_y;
    logic              r_last;
    logic [15:0]       y_sat;

    // Global advance: hold everything while a result is refused.
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // Input register: magnitude and sign of x.
    always_comb begin
        n_in       = '0;
        n_in.valid = i_valid;
        n_in.last  = i_last_in;
        n_in.neg   = i_x_in[15];
        n_in.mag   = i_x_in[15] ? (16'd0 - i_x_in) : i_x_in;
        n_in.one   = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (en) begin
            r_in <= n_in;
        end
    end

    assign exp_bus[0] = r_in;

    // Exponential chain, one table bit per stage.
    for (genvar k = 0; k < lsu_pkg::ExpSteps; k++) begin : g_exp
        lsu_exp_stage #(.K(k)) u_exp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (exp_bus[k]),
            .o_bus   (exp_bus[k+1])
        );
    end

    // Divisor D = 1 + E and the rounded numerator, split at the quotient width.
    always_comb begin
        e33    = {1'b0, exp_bus[lsu_pkg::ExpSteps].e};
        dsum   = (33'd1 << 32) + e33;
        if (exp_bus[lsu_pkg::ExpSteps].one) begin
            // A zero element gives D = 2.0, which does not fit; halving both
            // D and the even numerator leaves the quotient unchanged.
            dsum = 33'd1 << 32;
            num  = (50'd1 << 47) + (50'd1 << 31);
        end else if (exp_bus[lsu_pkg::ExpSteps].neg) begin
            num = {1'b0, e33, 16'd0} + {18'd0, dsum[32:1]};
        end else begin
            num = (50'd1 << 48) + {18'd0, dsum[32:1]};
        end
        n_prep       = '0;
        n_prep.valid = exp_bus[lsu_pkg::ExpSteps].valid;
        n_prep.last  = exp_bus[lsu_pkg::ExpSteps].last;
        n_prep.neg   = exp_bus[lsu_pkg::ExpSteps].neg;
        n_prep.d     = dsum;
        n_prep.rem   = num[49:17];
        n_prep.nlo   = num[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else if (en) begin
            r_prep <= n_prep;
        end
    end

    assign div_bus[0] = r_prep;

    // Division chain, one quotient bit per stage.
    for (genvar i = 0; i < lsu_pkg::QuotBits; i++) begin : g_div
        lsu_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (div_bus[i]),
            .o_bus   (div_bus[i+1])
        );
    end

    // Saturate 1.0 to the largest code.
    assign y_sat = div_bus[lsu_pkg::QuotBits].quot[16] ? 16'hFFFF
                                                       : div_bus[lsu_pkg::QuotBits].quot[15:0];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_bus[lsu_pkg::QuotBits].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y    <= y_sat;
            r_last <= div_bus[lsu_pkg::QuotBits].last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_y_out    = r_y;
    assign o_last_out = r_last;

endmodule
